// ===== sv/rsp_pkg.sv =====
`default_nettype none

package rsp_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam logic [1:0] REQ_CREATE = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_TEST   = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [14:0] rect_width;
        logic [14:0] rect_height;
        logic [3:0]  slot_index;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot_out;
        logic       hit;
    } t_rsp;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [14:0] w;
        logic [14:0] h;
    } t_rect;

    typedef enum logic [1:0] {
        RD_FREE = 2'd0,
        RD_IDX  = 2'd1,
        RD_HEAD = 2'd2,
        RD_LINK = 2'd3
    } t_rd_sel;

    typedef struct packed {
        logic    load_req;
        t_rd_sel rd_sel;
        logic    create_commit;
        logic    save_del_next;
        logic    del_head;
        logic    cur_from_head;
        logic    cur_from_link;
        logic    unlink_prev;
        logic    release_slot;
        logic    clear_lists;
        logic    res_full;
        logic    res_bad;
        logic    res_hit;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       free_null;
        logic       head_null;
        logic       del_bad;
        logic       head_is_idx;
        logic       link_is_idx;
        logic       link_null;
        logic       overlap;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/rect_slot_pool_overlap.sv =====
// Pool of SLOT_COUNT rectangle slots with a LIFO free list and a linked active list.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one request per beat:
// create, delete, overlap test or clear. Output channel (o_out_valid / i_out_ready /
// o_out_data) returns exactly one response beat per request, in order.
// One request is in flight at a time; o_in_ready is high only while the block is idle.
// Per request: create pops the free-list head and pushes it on the active list, clear
// resets both lists, test walks the active list from its head and stops at the first
// hit, delete unlinks the slot (walking from the head to the slot ahead of it) and
// pushes it on the free list; a full table or a bad or inactive slot goes straight
// to the response. The next request is accepted in the cycle after its response is
// loaded. Each walk step is one read of the link and rectangle memories, whose
// registered read port sets the step rate.
// The response sits in an output register; a stalled receiver holds it and the
// block waits in its final state until the register frees.
// Reset (synchronous, active low) empties the active list, chains all slots on the
// free list starting at slot 0 and drops any pending response; no clearing pass.
`default_nettype none

module rect_slot_pool_overlap #(
    parameter int SLOT_COUNT = rsp_pkg::SLOT_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rsp_pkg::t_req i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output rsp_pkg::t_rsp      o_out_data
);

    rsp_pkg::t_cmd cmd;
    rsp_pkg::t_sts sts;

    rsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rsp_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// ===== sv/rsp_ctrl.sv =====
`default_nettype none

module rsp_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire rsp_pkg::t_sts i_sts,
    output rsp_pkg::t_cmd      o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_CR_WR    = 8'b0000_0100,
        S_DL_HEAD  = 8'b0000_1000,
        S_DL_WALK  = 8'b0001_0000,
        S_DL_FREE  = 8'b0010_0000,
        S_TS_CHK   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = rsp_pkg::RD_LINK;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.req_type)
                    rsp_pkg::REQ_CREATE: begin
                        if (i_sts.free_null) begin
                            o_cmd.res_full = 1'b1;
                            n_state        = S_DONE;
                        end else begin
                            o_cmd.rd_sel = rsp_pkg::RD_FREE;
                            n_state      = S_CR_WR;
                        end
                    end
                    rsp_pkg::REQ_DELETE: begin
                        if (i_sts.del_bad) begin
                            o_cmd.res_bad = 1'b1;
                            n_state       = S_DONE;
                        end else begin
                            o_cmd.rd_sel = rsp_pkg::RD_IDX;
                            n_state      = S_DL_HEAD;
                        end
                    end
                    rsp_pkg::REQ_TEST: begin
                        if (i_sts.head_null) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.rd_sel = rsp_pkg::RD_HEAD;
                            n_state      = S_TS_CHK;
                        end
                    end
                    rsp_pkg::REQ_CLEAR: begin
                        o_cmd.clear_lists = 1'b1;
                        n_state           = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CR_WR: begin
                o_cmd.create_commit = 1'b1;
                n_state             = S_DONE;
            end
            S_DL_HEAD: begin
                o_cmd.save_del_next = 1'b1;
                if (i_sts.head_is_idx) begin
                    o_cmd.del_head = 1'b1;
                    n_state        = S_DL_FREE;
                end else begin
                    o_cmd.cur_from_head = 1'b1;
                    o_cmd.rd_sel        = rsp_pkg::RD_HEAD;
                    n_state             = S_DL_WALK;
                end
            end
            S_DL_WALK: begin
                if (i_sts.link_is_idx) begin
                    o_cmd.unlink_prev = 1'b1;
                    n_state           = S_DL_FREE;
                end else begin
                    o_cmd.cur_from_link = 1'b1;
                    o_cmd.rd_sel        = rsp_pkg::RD_LINK;
                end
            end
            S_DL_FREE: begin
                o_cmd.release_slot = 1'b1;
                n_state            = S_DONE;
            end
            S_TS_CHK: begin
                if (i_sts.overlap) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = S_DONE;
                end else if (i_sts.link_null) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_sel = rsp_pkg::RD_LINK;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== sv/rsp_dp.sv =====
`default_nettype none

module rsp_dp #(
    parameter int SLOT_COUNT = rsp_pkg::SLOT_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rsp_pkg::t_req i_in_data,
    input  wire rsp_pkg::t_cmd i_cmd,
    output rsp_pkg::t_sts      o_sts,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output rsp_pkg::t_rsp      o_out_data
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LW = IW + 1;
    localparam int XW = IW + 4;
    localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);

    rsp_pkg::t_req  r_req;
    rsp_pkg::t_rsp  r_res;
    rsp_pkg::t_rsp  r_out;
    logic           r_out_valid;
    logic [LW-1:0]  r_free_head;
    logic [LW-1:0]  r_active_head;
    logic [LW-1:0]  r_cur;
    logic [LW-1:0]  r_del_next;
    logic [SLOT_COUNT-1:0] r_mask;
    logic [SLOT_COUNT-1:0] r_link_vld;

    logic [LW-1:0]  r_link_mem [SLOT_COUNT];
    rsp_pkg::t_rect r_rect_mem [SLOT_COUNT];

    logic [LW-1:0]  r_link_q;
    logic           r_link_q_vld;
    logic [IW-1:0]  r_rd_addr_q;
    rsp_pkg::t_rect r_rect_q;

    logic [XW-1:0]  idx_x;
    logic [IW-1:0]  idx_addr;
    logic [IW-1:0]  fh_addr;
    logic [IW-1:0]  ah_addr;
    logic [IW-1:0]  cur_addr;
    logic [IW-1:0]  rd_addr;
    logic [LW-1:0]  link_val;
    logic           head_null;
    logic           free_null;

    logic signed [16:0] q_x, q_y, q_xe, q_ye;
    logic signed [16:0] s_x, s_y, s_xe, s_ye;

    assign idx_x    = XW'(r_req.slot_index);
    assign idx_addr = idx_x[IW-1:0];
    assign fh_addr  = r_free_head[IW-1:0];
    assign ah_addr  = r_active_head[IW-1:0];
    assign cur_addr = r_cur[IW-1:0];

    // entries never written since reset or clear hold the initial chain i+1
    assign link_val = r_link_q_vld ? r_link_q : ({1'b0, r_rd_addr_q} + LW'(1));

    assign head_null = (r_active_head == NIL);
    assign free_null = (r_free_head == NIL);

    always_comb begin
        case (i_cmd.rd_sel)
            rsp_pkg::RD_FREE: rd_addr = fh_addr;
            rsp_pkg::RD_IDX:  rd_addr = idx_addr;
            rsp_pkg::RD_HEAD: rd_addr = ah_addr;
            rsp_pkg::RD_LINK: rd_addr = link_val[IW-1:0];
            default:          rd_addr = link_val[IW-1:0];
        endcase
    end

    // half-open overlap, 17-bit sums cannot wrap
    assign q_x  = {r_req.rect_x[15], r_req.rect_x};
    assign q_y  = {r_req.rect_y[15], r_req.rect_y};
    assign q_xe = {r_req.rect_x[15], r_req.rect_x} + {2'b00, r_req.rect_width};
    assign q_ye = {r_req.rect_y[15], r_req.rect_y} + {2'b00, r_req.rect_height};
    assign s_x  = {r_rect_q.x[15], r_rect_q.x};
    assign s_y  = {r_rect_q.y[15], r_rect_q.y};
    assign s_xe = {r_rect_q.x[15], r_rect_q.x} + {2'b00, r_rect_q.w};
    assign s_ye = {r_rect_q.y[15], r_rect_q.y} + {2'b00, r_rect_q.h};

    always_comb begin
        o_sts.req_type    = r_req.req_type;
        o_sts.free_null   = free_null;
        o_sts.head_null   = head_null;
        o_sts.del_bad     = (idx_x >= XW'(SLOT_COUNT)) || !r_mask[idx_addr];
        o_sts.head_is_idx = (r_active_head == {1'b0, idx_addr});
        o_sts.link_is_idx = (link_val == {1'b0, idx_addr});
        o_sts.link_null   = (link_val == NIL);
        o_sts.overlap     = (q_x < s_xe) && (s_x < q_xe) && (q_y < s_ye) && (s_y < q_ye);
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head   <= '0;
            r_active_head <= NIL;
            r_mask        <= '0;
            r_link_vld    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear_lists) begin
                r_free_head   <= '0;
                r_active_head <= NIL;
                r_mask        <= '0;
                r_link_vld    <= '0;
            end
            if (i_cmd.create_commit) begin
                r_free_head          <= link_val;
                r_active_head        <= {1'b0, fh_addr};
                r_mask[fh_addr]      <= 1'b1;
                r_link_vld[fh_addr]  <= 1'b1;
            end
            if (i_cmd.del_head) begin
                r_active_head <= link_val;
            end
            if (i_cmd.unlink_prev) begin
                r_link_vld[cur_addr] <= 1'b1;
            end
            if (i_cmd.release_slot) begin
                r_mask[idx_addr]     <= 1'b0;
                r_link_vld[idx_addr] <= 1'b1;
                r_free_head          <= {1'b0, idx_addr};
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.create_commit) begin
            r_link_mem[fh_addr] <= r_active_head;
            r_rect_mem[fh_addr] <= {r_req.rect_x, r_req.rect_y,
                                    r_req.rect_width, r_req.rect_height};
        end else if (i_cmd.unlink_prev) begin
            r_link_mem[cur_addr] <= r_del_next;
        end else if (i_cmd.release_slot) begin
            r_link_mem[idx_addr] <= r_free_head;
        end
        r_link_q     <= r_link_mem[rd_addr];
        r_rect_q     <= r_rect_mem[rd_addr];
        r_link_q_vld <= r_link_vld[rd_addr];
        r_rd_addr_q  <= rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_in_data;
            r_res <= '0;
        end
        if (i_cmd.res_full) begin
            r_res.status <= rsp_pkg::ST_FULL;
        end
        if (i_cmd.res_bad) begin
            r_res.status <= rsp_pkg::ST_BAD;
        end
        if (i_cmd.res_hit) begin
            r_res.hit <= 1'b1;
        end
        if (i_cmd.create_commit) begin
            r_res.slot_out <= 4'(fh_addr);
        end
        if (i_cmd.save_del_next) begin
            r_del_next <= link_val;
        end
        if (i_cmd.cur_from_head) begin
            r_cur <= r_active_head;
        end else if (i_cmd.cur_from_link) begin
            r_cur <= link_val;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_heads_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!head_null && !free_null) |-> (r_active_head != r_free_head))
        else $error("active and free list share a head slot");

    a_head_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !head_null |-> r_mask[ah_addr])
        else $error("active list head is not marked active");

    a_free_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !free_null |-> !r_mask[fh_addr])
        else $error("free list head is marked active");

    a_clear_lists: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_lists |=> (head_null && (r_free_head == '0) && (r_mask == '0)))
        else $error("clear did not restore the lists");

endmodule

`default_nettype wire
